// ===== rtl/max_pool_2d_stream_assert.svh =====
// ----------------------------------------------------------------------------
// max_pool_2d_stream assertion macros
// Shorthand for the concurrent checks of the max pooling block.
// ----------------------------------------------------------------------------
`ifndef MAX_POOL_2D_STREAM_ASSERT_SVH
`define MAX_POOL_2D_STREAM_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define MP2D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("max pool check failed in %m");

// Consequent must hold in the same cycle as the antecedent.
`define MP2D_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("max pool check failed in %m");

// Consequent must hold in the cycle after reset is sampled active.
`define MP2D_ASSERT_RESET(label, clk, rst_n, cons) \
  label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("max pool reset check failed in %m");

`endif

// ===== rtl/mp2d_pkg.sv =====
// ----------------------------------------------------------------------------
// mp2d_pkg
// Shared types and constants of the streaming 2-D max pooling block.
// ----------------------------------------------------------------------------
package mp2d_pkg;

  // Configuration port.
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 11;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_IN_WIDTH  = 3'd0,
    REG_IN_HEIGHT = 3'd1,
    REG_CHANNELS  = 3'd2,
    REG_KERNEL_H  = 3'd3,
    REG_KERNEL_W  = 3'd4,
    REG_STRIDE_H  = 3'd5,
    REG_STRIDE_W  = 3'd6
  } reg_idx_t;

  // Register widths.
  localparam int W_REG_BITS  = 9;
  localparam int H_REG_BITS  = 11;
  localparam int CH_REG_BITS = 11;
  localparam int K_REG_BITS  = 4;
  localparam int S_REG_BITS  = 4;

  // Register reset values.
  localparam logic [W_REG_BITS-1:0]  IN_WIDTH_RST  = 9'd16;
  localparam logic [H_REG_BITS-1:0]  IN_HEIGHT_RST = 11'd16;
  localparam logic [CH_REG_BITS-1:0] CHANNELS_RST  = 11'd1;
  localparam logic [K_REG_BITS-1:0]  KERNEL_RST    = 4'd2;
  localparam logic [S_REG_BITS-1:0]  STRIDE_RST    = 4'd2;

  // Plane height and channel count saturate at this bound.
  localparam logic [H_REG_BITS-1:0] MAX_PLANE = 11'd1024;

  // Effective kernel size, wide enough for any kernel bound up to 16.
  localparam int KEFF_BITS = 5;

  // Output coordinate widths.
  localparam int CHAN_BITS = 10;
  localparam int ROW_BITS  = 10;
  localparam int COL_BITS  = 8;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;    // item taken this cycle
    logic issue;     // read one window column from all row banks
    logic load_out;  // move the finished window into the output register
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic fire;      // the item at the input completes a window
    logic rd_last;   // the column being issued is the rightmost of the window
    logic out_busy;  // output register holds an item that is not taken now
  } sts_t;

endpackage

// ===== rtl/mp2d_if.sv =====
// ----------------------------------------------------------------------------
// mp2d_if
// Valid/ready channel interfaces for samples in and pooled results out.
// ----------------------------------------------------------------------------
interface mp2d_in_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface mp2d_out_if #(
  parameter int SAMPLE_BITS = 16
) ();
  import mp2d_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] max_value;
  logic [CHAN_BITS-1:0]          out_channel;
  logic [ROW_BITS-1:0]           out_row;
  logic [COL_BITS-1:0]           out_col;
  logic                          last;

  modport source (output valid, output max_value, output out_channel, output out_row,
                  output out_col, output last, input ready);
  modport sink   (input valid, input max_value, input out_channel, input out_row,
                  input out_col, input last, output ready);
endinterface

// ===== rtl/mp2d_ctrl.sv =====
// ----------------------------------------------------------------------------
// mp2d_ctrl
// Sequencer of the max pooling block: accepts items and walks window columns.
// ----------------------------------------------------------------------------
module mp2d_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  mp2d_pkg::sts_t  sts,
  output mp2d_pkg::cmd_t  cmd
);
  import mp2d_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.issue    = 1'b0;
    cmd.load_out = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && sts.fire) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.issue = 1'b1;
        if (sts.rd_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/mp2d_datapath.sv =====
// ----------------------------------------------------------------------------
// mp2d_datapath
// Registers, position tracking, banked line store and window maximum.
// ----------------------------------------------------------------------------
module mp2d_datapath #(
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_KERNEL  = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [mp2d_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
  input  logic [mp2d_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample,
  input  mp2d_pkg::cmd_t                       cmd,
  output mp2d_pkg::sts_t                       sts,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic signed [SAMPLE_BITS-1:0]        out_max_value,
  output logic [mp2d_pkg::CHAN_BITS-1:0]       out_channel,
  output logic [mp2d_pkg::ROW_BITS-1:0]        out_row,
  output logic [mp2d_pkg::COL_BITS-1:0]        out_col,
  output logic                                 out_last
);
  import mp2d_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int BW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int WW = (CW + 1 > W_REG_BITS) ? CW + 1 : W_REG_BITS;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Configuration registers.
  logic [W_REG_BITS-1:0]  in_width_r;
  logic [H_REG_BITS-1:0]  in_height_r;
  logic [CH_REG_BITS-1:0] channels_r;
  logic [K_REG_BITS-1:0]  kernel_h_r;
  logic [K_REG_BITS-1:0]  kernel_w_r;
  logic [S_REG_BITS-1:0]  stride_h_r;
  logic [S_REG_BITS-1:0]  stride_w_r;
  logic                   cfg_hit;

  // Effective sizes after clamping.
  logic [WW-1:0]          w_eff;
  logic [H_REG_BITS-1:0]  h_eff;
  logic [CH_REG_BITS-1:0] chn_eff;
  logic [KEFF_BITS-1:0]   kh_eff;
  logic [KEFF_BITS-1:0]   kw_eff;
  logic [S_REG_BITS-1:0]  sh_eff;
  logic [S_REG_BITS-1:0]  sw_eff;

  // Position of the next item and stride phase of the window origins.
  logic [CW-1:0]         col_r, col_nxt;
  logic [ROW_BITS-1:0]   row_r, row_nxt;
  logic [CHAN_BITS-1:0]  chan_r, chan_nxt;
  logic [S_REG_BITS-1:0] cmod_r, cmod_nxt;
  logic [COL_BITS-1:0]   cdiv_r, cdiv_nxt;
  logic [S_REG_BITS-1:0] rmod_r, rmod_nxt;
  logic [ROW_BITS-1:0]   rdiv_r, rdiv_nxt;
  logic [BW-1:0]         bank_r, bank_nxt;

  logic [WW-1:0]         c_ext;
  logic [WW-1:0]         c_inc;
  logic [H_REG_BITS-1:0] r_inc;
  logic                  col_end;
  logic                  row_end;
  logic                  chan_end;
  logic                  win_fire;
  logic                  win_last;

  // Window under evaluation.
  logic [CW-1:0]          rd_col_r;
  logic [CW-1:0]          rd_end_r;
  logic [MAX_KERNEL-1:0]  mask_r, mask_nxt;
  logic [BW:0]            row_gap [MAX_KERNEL];
  logic [CHAN_BITS-1:0]   win_chan_r;
  logic [ROW_BITS-1:0]    win_row_r;
  logic [COL_BITS-1:0]    win_col_r;
  logic                   win_last_r;

  logic signed [SAMPLE_BITS-1:0] rdata_r [MAX_KERNEL];
  logic                          rdat_vld_r;
  logic signed [SAMPLE_BITS-1:0] acc_r;
  logic signed [SAMPLE_BITS-1:0] best;

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_max_r;
  logic [CHAN_BITS-1:0]          out_chan_r;
  logic [ROW_BITS-1:0]           out_row_r;
  logic [COL_BITS-1:0]           out_col_r;
  logic                          out_last_r;

  // ---------------- configuration ----------------
  always_comb begin
    case (reg_idx_t'(cfg_idx))
      REG_IN_WIDTH, REG_IN_HEIGHT, REG_CHANNELS, REG_KERNEL_H,
      REG_KERNEL_W, REG_STRIDE_H, REG_STRIDE_W: cfg_hit = cfg_we;
      default:                                  cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_width_r  <= IN_WIDTH_RST;
      in_height_r <= IN_HEIGHT_RST;
      channels_r  <= CHANNELS_RST;
      kernel_h_r  <= KERNEL_RST;
      kernel_w_r  <= KERNEL_RST;
      stride_h_r  <= STRIDE_RST;
      stride_w_r  <= STRIDE_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_IN_WIDTH:  in_width_r  <= cfg_data[W_REG_BITS-1:0];
        REG_IN_HEIGHT: in_height_r <= cfg_data[H_REG_BITS-1:0];
        REG_CHANNELS:  channels_r  <= cfg_data[CH_REG_BITS-1:0];
        REG_KERNEL_H:  kernel_h_r  <= cfg_data[K_REG_BITS-1:0];
        REG_KERNEL_W:  kernel_w_r  <= cfg_data[K_REG_BITS-1:0];
        REG_STRIDE_H:  stride_h_r  <= cfg_data[S_REG_BITS-1:0];
        REG_STRIDE_W:  stride_w_r  <= cfg_data[S_REG_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Zero means one; larger values saturate at the supported bounds.
  always_comb begin
    if (in_width_r == '0) begin
      w_eff = WW'(1);
    end else if (WW'(in_width_r) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(in_width_r);
    end
    if (in_height_r == '0) begin
      h_eff = H_REG_BITS'(1);
    end else if (in_height_r > MAX_PLANE) begin
      h_eff = MAX_PLANE;
    end else begin
      h_eff = in_height_r;
    end
    if (channels_r == '0) begin
      chn_eff = CH_REG_BITS'(1);
    end else if (channels_r > MAX_PLANE) begin
      chn_eff = MAX_PLANE;
    end else begin
      chn_eff = channels_r;
    end
    if (kernel_h_r == '0) begin
      kh_eff = KEFF_BITS'(1);
    end else if (KEFF_BITS'(kernel_h_r) > KEFF_BITS'(MAX_KERNEL)) begin
      kh_eff = KEFF_BITS'(MAX_KERNEL);
    end else begin
      kh_eff = KEFF_BITS'(kernel_h_r);
    end
    if (kernel_w_r == '0) begin
      kw_eff = KEFF_BITS'(1);
    end else if (KEFF_BITS'(kernel_w_r) > KEFF_BITS'(MAX_KERNEL)) begin
      kw_eff = KEFF_BITS'(MAX_KERNEL);
    end else begin
      kw_eff = KEFF_BITS'(kernel_w_r);
    end
    sh_eff = (stride_h_r == '0) ? S_REG_BITS'(1) : stride_h_r;
    sw_eff = (stride_w_r == '0) ? S_REG_BITS'(1) : stride_w_r;
  end

  // ---------------- position tracking ----------------
  assign c_ext    = WW'(col_r);
  assign c_inc    = c_ext + WW'(1);
  assign r_inc    = H_REG_BITS'(row_r) + H_REG_BITS'(1);
  assign col_end  = (c_inc == w_eff);
  assign row_end  = (r_inc == h_eff);
  assign chan_end = (CH_REG_BITS'(chan_r) + CH_REG_BITS'(1) == chn_eff);

  // A window completes when both origin coordinates exist and sit on the stride grid.
  assign win_fire = (c_inc >= WW'(kw_eff)) && (r_inc >= H_REG_BITS'(kh_eff)) &&
                    (cmod_r == '0) && (rmod_r == '0);

  assign win_last = chan_end &&
                    ((H_REG_BITS + 1)'(row_r) + (H_REG_BITS + 1)'(sh_eff) >=
                     (H_REG_BITS + 1)'(h_eff)) &&
                    ((WW + 1)'(col_r) + (WW + 1)'(sw_eff) >= (WW + 1)'(w_eff));

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    chan_nxt = chan_r;
    cmod_nxt = cmod_r;
    cdiv_nxt = cdiv_r;
    rmod_nxt = rmod_r;
    rdiv_nxt = rdiv_r;
    bank_nxt = bank_r;
    if (col_end) begin
      col_nxt  = '0;
      cmod_nxt = '0;
      cdiv_nxt = '0;
      if (row_end) begin
        row_nxt  = '0;
        rmod_nxt = '0;
        rdiv_nxt = '0;
        bank_nxt = '0;
        chan_nxt = chan_end ? '0 : chan_r + CHAN_BITS'(1);
      end else begin
        row_nxt  = r_inc[ROW_BITS-1:0];
        bank_nxt = (bank_r == BW'(MAX_KERNEL - 1)) ? '0 : bank_r + BW'(1);
        if (r_inc < H_REG_BITS'(kh_eff)) begin
          rmod_nxt = '0;
          rdiv_nxt = '0;
        end else if (rmod_r == sh_eff - S_REG_BITS'(1)) begin
          rmod_nxt = '0;
          rdiv_nxt = rdiv_r + ROW_BITS'(1);
        end else begin
          rmod_nxt = rmod_r + S_REG_BITS'(1);
        end
      end
    end else begin
      col_nxt = c_inc[CW-1:0];
      if (c_inc < WW'(kw_eff)) begin
        cmod_nxt = '0;
        cdiv_nxt = '0;
      end else if (cmod_r == sw_eff - S_REG_BITS'(1)) begin
        cmod_nxt = '0;
        cdiv_nxt = cdiv_r + COL_BITS'(1);
      end else begin
        cmod_nxt = cmod_r + S_REG_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      col_r  <= '0;
      row_r  <= '0;
      chan_r <= '0;
      cmod_r <= '0;
      cdiv_r <= '0;
      rmod_r <= '0;
      rdiv_r <= '0;
      bank_r <= '0;
    end else if (cmd.accept) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      chan_r <= chan_nxt;
      cmod_r <= cmod_nxt;
      cdiv_r <= cdiv_nxt;
      rmod_r <= rmod_nxt;
      rdiv_r <= rdiv_nxt;
      bank_r <= bank_nxt;
    end
  end

  // ---------------- window capture ----------------
  // Bank b holds the row that lies row_gap[b] rows above the current one.
  always_comb begin
    for (int b = 0; b < MAX_KERNEL; b++) begin
      if (bank_r >= BW'(b)) begin
        row_gap[b] = (BW + 1)'(bank_r) - (BW + 1)'(b);
      end else begin
        row_gap[b] = (BW + 1)'(bank_r) + (BW + 1)'(MAX_KERNEL) - (BW + 1)'(b);
      end
      mask_nxt[b] = (KEFF_BITS'(row_gap[b]) < kh_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_col_r   <= CW'(c_inc - WW'(kw_eff));
      rd_end_r   <= col_r;
      mask_r     <= mask_nxt;
      win_chan_r <= chan_r;
      win_row_r  <= rdiv_r;
      win_col_r  <= cdiv_r;
      win_last_r <= win_last;
    end else if (cmd.issue) begin
      rd_col_r <= rd_col_r + CW'(1);
    end
  end

  // ---------------- line store, one bank per row ----------------
  for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_bank
    logic signed [SAMPLE_BITS-1:0] mem [MAX_WIDTH];

    always_ff @(posedge clk) begin
      if (cmd.accept && (bank_r == BW'(b))) begin
        mem[col_r] <= in_sample;
      end
      rdata_r[b] <= mem[rd_col_r];
    end
  end

  // ---------------- maximum ----------------
  always_comb begin
    best = acc_r;
    for (int b = 0; b < MAX_KERNEL; b++) begin
      if (mask_r[b] && (rdata_r[b] > best)) begin
        best = rdata_r[b];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdat_vld_r <= 1'b0;
    end else begin
      rdat_vld_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      acc_r <= SAMPLE_MIN;
    end else if (rdat_vld_r) begin
      acc_r <= best;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_max_r  <= acc_r;
      out_chan_r <= win_chan_r;
      out_row_r  <= win_row_r;
      out_col_r  <= win_col_r;
      out_last_r <= win_last_r;
    end
  end

  assign sts.fire     = win_fire;
  assign sts.rd_last  = (rd_col_r == rd_end_r);
  assign sts.out_busy = out_valid_r && !out_ready;

  assign out_valid     = out_valid_r;
  assign out_max_value = out_max_r;
  assign out_channel   = out_chan_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_last      = out_last_r;

endmodule

// ===== rtl/max_pool_2d_stream.sv =====
// ----------------------------------------------------------------------------
// max_pool_2d_stream
// Streaming 2-D max pooling over a channel-planar tensor of Q8.8 samples.
// ----------------------------------------------------------------------------
// Samples enter one item at a time in raster order: column fastest, then row,
// then channel. An item that is the bottom-right corner of a window whose
// origin lies on the stride grid produces one result item carrying the
// window maximum and its output channel, row and column; every other item
// produces nothing. An item that completes no window is taken at once, and
// the next item can follow right behind it. An item that completes a window
// is stored, then each window column is read from all row banks of the
// line store at once, then the last column is folded in, and then the
// output register is loaded as soon as the previous result is taken. The line
// store has one bank per kernel row, so the window width is what sets the
// rate. The output register is separate from the input side, so the next
// item is taken while a result still waits downstream. The line store needs
// no clearing pass after reset: a window only reads entries written earlier
// in the same plane. A write to any of the seven configuration registers
// restarts the tensor position at channel 0, row 0, column 0. Registers
// must be written only while the block is idle; no logic enforces this.
// ----------------------------------------------------------------------------
module max_pool_2d_stream #(
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_KERNEL  = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  mp2d_in_if.sink                             in_ch,
  mp2d_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [mp2d_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
  input  logic [mp2d_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import mp2d_pkg::*;

  // Commands from the sequencer and status back from the datapath.
  cmd_t cmd;
  sts_t sts;

  // The sequencer decides when an item is taken and when a window column is
  // read; it never touches data itself.
  mp2d_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the registers, the tensor position, the banked line
  // store, the running maximum and the output register.
  mp2d_datapath #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_KERNEL  (MAX_KERNEL),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_data      (cfg_data),
    .in_sample     (in_ch.sample),
    .cmd           (cmd),
    .sts           (sts),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_max_value (out_ch.max_value),
    .out_channel   (out_ch.out_channel),
    .out_row       (out_ch.out_row),
    .out_col       (out_ch.out_col),
    .out_last      (out_ch.last)
  );

endmodule

// ===== rtl/mp2d_checker.sv =====
// ----------------------------------------------------------------------------
// mp2d_checker
// Port-level checks of the max pooling block, bound to its top level.
// ----------------------------------------------------------------------------
`include "max_pool_2d_stream_assert.svh"

module mp2d_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] out_max_value
);

  // A result that is not taken stays offered and unchanged.
  `MP2D_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `MP2D_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_max_value))

  // A new result is only loaded while the input side is closed.
  `MP2D_ASSERT_NOW(a_load_closed, clk, rst_n, $rose(out_valid), !$past(in_ready))

  // Reset empties the output register.
  `MP2D_ASSERT_RESET(a_reset_empty, clk, rst_n, !out_valid)

endmodule

bind max_pool_2d_stream mp2d_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_mp2d_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_max_value (out_ch.max_value)
);

// ===== tb/sv/tb_max_pool_2d_stream.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_max_pool_2d_stream
// Self-checking testbench for the streaming 2-D max pooling block.
// ----------------------------------------------------------------------------
// A short table of directed items runs first: sample extremes, zero and
// saturated registers, the spare register index, a kernel taller than the
// plane and a tensor wrap. Random phases follow, each with its own register
// setting and its own idling pattern on both channels. Every accepted item is
// run through a local model of the pooling window, and every result item that
// leaves the block is compared field by field with the oldest pending window.
// ----------------------------------------------------------------------------
module tb_max_pool_2d_stream;
  import mp2d_pkg::*;

  localparam int POOL_MAX_WIDTH  = 256;
  localparam int POOL_MAX_KERNEL = 8;
  localparam int POOL_SAMPLE     = 16;
  localparam int STORE_SLOTS     = POOL_MAX_WIDTH * POOL_MAX_KERNEL;

  // Height and channel count saturate at 1024, strides at 15.
  localparam int PLANE_LIMIT  = 1024;
  localparam int STRIDE_LIMIT = 15;

  // The index one past the last register; the block must ignore writes to it.
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 3'd7;

  // Idling rates in percent, the long output hold-off and the drain bounds.
  localparam int HEAVY_PCT     = 83;
  localparam int LIGHT_PCT     = 6;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_LIMIT   = 20000;

  // Random part stops once both of these are reached.
  localparam int RAND_ITEMS   = 240;
  localparam int RAND_WINDOWS = 48;

  // Planes in the many-channel run near the end.
  localparam int DEEP_CHANNELS = 60;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic signed [POOL_SAMPLE-1:0] max_value;
    logic [CHAN_BITS-1:0]          out_channel;
    logic [ROW_BITS-1:0]           out_row;
    logic [COL_BITS-1:0]           out_col;
    logic                          last;
  } pool_res_t;

  // One row of the directed table: either a register write or a sample.
  // Rows marked typed carry a result read straight off the setting.
  typedef struct packed {
    logic                    is_cfg;
    logic [CFG_IDX_BITS-1:0] idx;
    logic [CFG_DATA_BITS-1:0] data;
    logic [POOL_SAMPLE-1:0]  sample;
    logic                    typed;
    pool_res_t               want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  mp2d_in_if  #(.SAMPLE_BITS(POOL_SAMPLE)) in_if ();
  mp2d_out_if #(.SAMPLE_BITS(POOL_SAMPLE)) out_if ();

  max_pool_2d_stream #(
    .MAX_WIDTH   (POOL_MAX_WIDTH),
    .MAX_KERNEL  (POOL_MAX_KERNEL),
    .SAMPLE_BITS (POOL_SAMPLE)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the block: register file, line store and tensor position.
  logic [CFG_DATA_BITS-1:0]      cfg_shadow [7];
  logic signed [POOL_SAMPLE-1:0] line_copy [STORE_SLOTS];
  int pos_col;
  int pos_row;
  int pos_chan;

  // Windows predicted but not yet seen at the output, oldest first.
  pool_res_t windows_due [$];

  idle_mode_t idle_mode = IDLE_NONE;
  int hold_reqs       = 0;
  int errors          = 0;
  int items_sent      = 0;
  int windows_pushed  = 0;
  int results_checked = 0;

  task automatic flag_error(input string msg);
    errors++;
    $display("MISMATCH at %0t ns: %s", $realtime, msg);
  endtask

  function automatic int eff_reg(input logic [CFG_DATA_BITS-1:0] v, input int hi);
    if (v == '0) return 1;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  function automatic int reg_bits(input logic [CFG_IDX_BITS-1:0] idx);
    case (idx)
      REG_IN_WIDTH:               return W_REG_BITS;
      REG_IN_HEIGHT:              return H_REG_BITS;
      REG_CHANNELS:               return CH_REG_BITS;
      REG_KERNEL_H, REG_KERNEL_W: return K_REG_BITS;
      default:                    return S_REG_BITS;
    endcase
  endfunction

  function automatic int slot_of(input int row, input int col);
    return (row % POOL_MAX_KERNEL) * POOL_MAX_WIDTH + col;
  endfunction

  // Stores the sample at its position, and when that position is the
  // bottom-right corner of a window on the stride grid, works out the
  // window maximum and its output coordinates. Then advances the position.
  function automatic bit pool_step(input logic signed [POOL_SAMPLE-1:0] s,
                                   output pool_res_t res);
    int w, h, chn, kh, kw, sh, sw;
    int r, c, ch, top, left, i, j;
    logic signed [POOL_SAMPLE-1:0] best;
    bit fire;
    w   = eff_reg(cfg_shadow[REG_IN_WIDTH], POOL_MAX_WIDTH);
    h   = eff_reg(cfg_shadow[REG_IN_HEIGHT], PLANE_LIMIT);
    chn = eff_reg(cfg_shadow[REG_CHANNELS], PLANE_LIMIT);
    kh  = eff_reg(cfg_shadow[REG_KERNEL_H], POOL_MAX_KERNEL);
    kw  = eff_reg(cfg_shadow[REG_KERNEL_W], POOL_MAX_KERNEL);
    sh  = eff_reg(cfg_shadow[REG_STRIDE_H], STRIDE_LIMIT);
    sw  = eff_reg(cfg_shadow[REG_STRIDE_W], STRIDE_LIMIT);
    res  = '0;
    fire = 1'b0;
    r  = (pos_row >= h) ? 0 : pos_row;
    c  = (pos_col >= w) ? 0 : pos_col;
    ch = (pos_chan >= chn) ? 0 : pos_chan;
    line_copy[slot_of(r, c)] = s;
    if (r + 1 >= kh && c + 1 >= kw && (r + 1 - kh) % sh == 0 && (c + 1 - kw) % sw == 0) begin
      top  = r + 1 - kh;
      left = c + 1 - kw;
      best = line_copy[slot_of(top, left)];
      for (i = top; i <= r; i++) begin
        for (j = left; j <= c; j++) begin
          if (line_copy[slot_of(i, j)] > best) best = line_copy[slot_of(i, j)];
        end
      end
      res.max_value   = best;
      res.out_channel = CHAN_BITS'(ch);
      res.out_row     = ROW_BITS'(top / sh);
      res.out_col     = COL_BITS'(left / sw);
      res.last        = (ch + 1 == chn) && (r + sh >= h) && (c + sw >= w);
      fire = 1'b1;
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) begin
        r = 0;
        ch++;
        if (ch >= chn) ch = 0;
      end
    end
    pos_col  = c;
    pos_row  = r;
    pos_chan = ch;
    return fire;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_BITS-1:0] idx,
                                        input logic [CFG_DATA_BITS-1:0] data);
    stim_row_t row;
    row        = '0;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.data   = data;
    return row;
  endfunction

  function automatic stim_row_t smp_row(input logic signed [POOL_SAMPLE-1:0] s);
    stim_row_t row;
    row        = '0;
    row.sample = s;
    return row;
  endfunction

  function automatic stim_row_t chk_row(input logic signed [POOL_SAMPLE-1:0] s,
                                        input logic signed [POOL_SAMPLE-1:0] mx,
                                        input int ch, input int row_i, input int col,
                                        input logic last);
    stim_row_t row;
    row                  = '0;
    row.sample           = s;
    row.typed            = 1'b1;
    row.want.max_value   = mx;
    row.want.out_channel = CHAN_BITS'(ch);
    row.want.out_row     = ROW_BITS'(row_i);
    row.want.out_col     = COL_BITS'(col);
    row.want.last        = last;
    return row;
  endfunction

  // Sample mix: plenty of extremes and small values so that ties and
  // sign boundaries show up inside windows, the rest fully random.
  function automatic logic signed [POOL_SAMPLE-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3:    return POOL_SAMPLE'($urandom_range(8)) - 16'sd4;
      default: return POOL_SAMPLE'($urandom);
    endcase
  endfunction

  // Now and then sets the data bits above the register width, which the
  // block must drop.
  function automatic logic [CFG_DATA_BITS-1:0] noisy(input int v, input int bits);
    logic [CFG_DATA_BITS-1:0] junk;
    junk = CFG_DATA_BITS'($urandom) & ~CFG_DATA_BITS'((1 << bits) - 1);
    if ($urandom_range(3) == 0) return CFG_DATA_BITS'(v) | junk;
    return CFG_DATA_BITS'(v);
  endfunction

  // A write always waits for a rising edge before it starts, so that the write
  // enable never gets two assignments in one time step.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx != REG_SPARE) begin
      cfg_shadow[idx] = val & CFG_DATA_BITS'((1 << reg_bits(idx)) - 1);
      pos_col  = 0;
      pos_row  = 0;
      pos_chan = 0;
    end
  endtask

  // Offers one item and returns in the time step of its handshake, with
  // valid still high. The caller either offers the next item or lowers
  // valid in that same step. Ready is looked at on the falling edge, where
  // it is settled, and the handshake then happens on the next rising edge.
  task automatic send_item(input logic signed [POOL_SAMPLE-1:0] s, input bit typed,
                           input pool_res_t want);
    bit take;
    pool_res_t res;
    while ((idle_mode == IDLE_SEND && $urandom_range(99) < HEAVY_PCT) ||
           (idle_mode == IDLE_BOTH && $urandom_range(99) < LIGHT_PCT)) begin
      in_if.valid  <= 1'b0;
      in_if.sample <= POOL_SAMPLE'($urandom);
      @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    take = 1'b0;
    while (!take) begin
      @(negedge clk);
      take = in_if.ready;
      @(posedge clk);
    end
    items_sent++;
    if (pool_step(s, res)) begin
      windows_due.push_back(typed ? want : res);
      windows_pushed++;
    end else if (typed) begin
      windows_due.push_back(want);
    end
  endtask

  // Stops offering, waits for every pending window, then lets the block
  // finish any item that makes no result before the next register write.
  task automatic settle();
    int waited;
    in_if.valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (windows_due.size() != 0 && waited < DRAIN_LIMIT);
    if (windows_due.size() != 0) begin
      flag_error($sformatf("%0d expected windows never came out", windows_due.size()));
      windows_due.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Output side: checks on the falling edge the item that the next rising
  // edge takes, then picks ready for the following cycle. A hold-off
  // request from the stimulus side keeps ready low for a long counted run.
  initial begin
    int hold_left;
    int hold_seen;
    pool_res_t got;
    pool_res_t want;
    hold_left    = 0;
    hold_seen    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        got.max_value   = out_if.max_value;
        got.out_channel = out_if.out_channel;
        got.out_row     = out_if.out_row;
        got.out_col     = out_if.out_col;
        got.last        = out_if.last;
        if (windows_due.size() == 0) begin
          flag_error($sformatf("unexpected result max %0d ch %0d row %0d col %0d last %0b",
                               got.max_value, got.out_channel, got.out_row, got.out_col,
                               got.last));
        end else begin
          want = windows_due.pop_front();
          results_checked++;
          if (got.max_value !== want.max_value)
            flag_error($sformatf("max_value %0d, expected %0d", got.max_value,
                                 want.max_value));
          if (got.out_channel !== want.out_channel)
            flag_error($sformatf("out_channel %0d, expected %0d", got.out_channel,
                                 want.out_channel));
          if (got.out_row !== want.out_row)
            flag_error($sformatf("out_row %0d, expected %0d", got.out_row, want.out_row));
          if (got.out_col !== want.out_col)
            flag_error($sformatf("out_col %0d, expected %0d", got.out_col, want.out_col));
          if (got.last !== want.last)
            flag_error($sformatf("last %0b, expected %0b", got.last, want.last));
        end
      end
      @(posedge clk);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (idle_mode == IDLE_RECV) begin
        out_if.ready <= ($urandom_range(99) >= HEAVY_PCT);
      end else if (idle_mode == IDLE_BOTH) begin
        out_if.ready <= ($urandom_range(99) >= LIGHT_PCT);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Stimulus.
  initial begin
    stim_row_t plan [$];
    stim_row_t row;
    int vals [7];
    int k, r_i, n, phase, size, dir_items, dir_windows;
    bit wide;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    in_if.valid  = 1'b0;
    in_if.sample = '0;

    cfg_shadow[REG_IN_WIDTH]  = CFG_DATA_BITS'(IN_WIDTH_RST);
    cfg_shadow[REG_IN_HEIGHT] = CFG_DATA_BITS'(IN_HEIGHT_RST);
    cfg_shadow[REG_CHANNELS]  = CFG_DATA_BITS'(CHANNELS_RST);
    cfg_shadow[REG_KERNEL_H]  = CFG_DATA_BITS'(KERNEL_RST);
    cfg_shadow[REG_KERNEL_W]  = CFG_DATA_BITS'(KERNEL_RST);
    cfg_shadow[REG_STRIDE_H]  = CFG_DATA_BITS'(STRIDE_RST);
    cfg_shadow[REG_STRIDE_W]  = CFG_DATA_BITS'(STRIDE_RST);
    for (k = 0; k < STORE_SLOTS; k++) line_copy[k] = '0;
    pos_col  = 0;
    pos_row  = 0;
    pos_chan = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. The first item runs on the reset setting.
    plan.push_back(smp_row(16'sh0100));
    // A two-column, one-row plane with a 1x1 window: each item is its own
    // maximum, the second one closes the tensor and the third starts anew.
    plan.push_back(cfg_row(REG_IN_WIDTH, 11'd2));
    plan.push_back(cfg_row(REG_IN_HEIGHT, 11'd1));
    plan.push_back(cfg_row(REG_CHANNELS, 11'd1));
    plan.push_back(cfg_row(REG_KERNEL_H, 11'd1));
    plan.push_back(cfg_row(REG_KERNEL_W, 11'd1));
    plan.push_back(cfg_row(REG_STRIDE_H, 11'd1));
    plan.push_back(cfg_row(REG_STRIDE_W, 11'd1));
    plan.push_back(chk_row(16'sh7FFF, 16'sh7FFF, 0, 0, 0, 1'b0));
    plan.push_back(chk_row(16'sh8000, 16'sh8000, 0, 0, 1, 1'b1));
    plan.push_back(chk_row(16'sh0000, 16'sh0000, 0, 0, 0, 1'b0));
    // A 1x2 window over the same plane: the write restarts at column zero.
    plan.push_back(cfg_row(REG_KERNEL_W, 11'd2));
    plan.push_back(smp_row(16'sh8000));
    plan.push_back(chk_row(16'shFFFF, 16'shFFFF, 0, 0, 0, 1'b1));
    // Zero width and kernel width are taken as one.
    plan.push_back(cfg_row(REG_IN_WIDTH, 11'd0));
    plan.push_back(cfg_row(REG_KERNEL_W, 11'd0));
    plan.push_back(chk_row(16'sh1234, 16'sh1234, 0, 0, 0, 1'b1));
    plan.push_back(chk_row(16'sh8001, 16'sh8001, 0, 0, 0, 1'b1));
    // A write to the spare index must not move the tensor position.
    plan.push_back(cfg_row(REG_IN_WIDTH, 11'd3));
    plan.push_back(smp_row(16'sh0042));
    plan.push_back(cfg_row(REG_SPARE, 11'd5));
    plan.push_back(smp_row(16'shFF00));
    // Kernel taller than the plane: nothing ever comes out.
    plan.push_back(cfg_row(REG_KERNEL_H, 11'd8));
    plan.push_back(smp_row(16'sh7FFF));
    plan.push_back(smp_row(16'sh8000));
    plan.push_back(smp_row(16'sh5555));
    // Sizes and kernels past bounds, strides 0 and 15, some high data bits set.
    plan.push_back(cfg_row(REG_IN_WIDTH, 11'd2047));
    plan.push_back(cfg_row(REG_IN_HEIGHT, 11'd2047));
    plan.push_back(cfg_row(REG_CHANNELS, 11'd2047));
    plan.push_back(cfg_row(REG_KERNEL_H, 11'd15));
    plan.push_back(cfg_row(REG_KERNEL_W, 11'd2047));
    plan.push_back(cfg_row(REG_STRIDE_H, 11'd0));
    plan.push_back(cfg_row(REG_STRIDE_W, 11'd15));
    plan.push_back(smp_row(16'shAAAA));
    plan.push_back(smp_row(16'sh0001));
    plan.push_back(smp_row(16'shFFFE));

    for (k = 0; k < plan.size(); k++) begin
      row = plan[k];
      if (row.is_cfg) begin
        settle();
        write_reg(row.idx, row.data);
      end else begin
        send_item(row.sample, row.typed, row.want);
      end
    end
    dir_items   = items_sent;
    dir_windows = windows_pushed;

    // Random phases. Most settings are small planes sent as whole tensors,
    // so that windows complete all the time; one in five reaches for zero
    // or saturated registers and is cut off after a bounded number of items.
    phase = 0;
    while (items_sent - dir_items < RAND_ITEMS || windows_pushed - dir_windows < RAND_WINDOWS)
    begin
      settle();
      idle_mode = idle_mode_t'(phase % 4);
      wide = ($urandom_range(4) == 0);
      if (wide) begin
        case ($urandom_range(3))
          0:       vals[REG_IN_WIDTH] = 0;
          1:       vals[REG_IN_WIDTH] = POOL_MAX_WIDTH;
          2:       vals[REG_IN_WIDTH] = $urandom_range(257, 511);
          default: vals[REG_IN_WIDTH] = $urandom_range(100, 255);
        endcase
        case ($urandom_range(3))
          0:       vals[REG_IN_HEIGHT] = 0;
          1:       vals[REG_IN_HEIGHT] = PLANE_LIMIT;
          2:       vals[REG_IN_HEIGHT] = $urandom_range(1025, 2047);
          default: vals[REG_IN_HEIGHT] = $urandom_range(1, 3);
        endcase
        vals[REG_CHANNELS] = $urandom_range(2) == 0 ? 0 : $urandom_range(1, 2047);
        vals[REG_KERNEL_H] = $urandom_range(15);
        vals[REG_KERNEL_W] = $urandom_range(15);
        vals[REG_STRIDE_H] = $urandom_range(15);
        vals[REG_STRIDE_W] = $urandom_range(15);
      end else begin
        vals[REG_IN_WIDTH]  = $urandom_range(1, 12);
        vals[REG_IN_HEIGHT] = $urandom_range(1, 10);
        vals[REG_CHANNELS]  = $urandom_range(1, 3);
        vals[REG_KERNEL_H]  = $urandom_range(1, 4);
        vals[REG_KERNEL_W]  = $urandom_range(1, 4);
        vals[REG_STRIDE_H]  = $urandom_range(1, 4);
        vals[REG_STRIDE_W]  = $urandom_range(1, 4);
      end
      for (r_i = 0; r_i < 7; r_i++)
        write_reg(CFG_IDX_BITS'(r_i), noisy(vals[r_i], reg_bits(CFG_IDX_BITS'(r_i))));
      if ($urandom_range(5) == 0) write_reg(REG_SPARE, CFG_DATA_BITS'($urandom));

      size = eff_reg(cfg_shadow[REG_IN_WIDTH], POOL_MAX_WIDTH) *
             eff_reg(cfg_shadow[REG_IN_HEIGHT], PLANE_LIMIT) *
             eff_reg(cfg_shadow[REG_CHANNELS], PLANE_LIMIT);
      // Whole tensors, sometimes with a few items of the next one left
      // hanging when the next setting cuts in.
      if (size <= 64)
        n = size * $urandom_range(1, 3) + ($urandom_range(3) == 0 ? $urandom_range(1, 5) : 0);
      else
        n = $urandom_range(40, 150);

      for (k = 0; k < n; k++) begin
        // The output stops taking items for a long run while items keep
        // being offered, so the block backs up into its input.
        if (phase % 8 == 1 && k == n / 4) hold_reqs++;
        // The input goes quiet until every pending window has come out.
        if (phase % 8 == 2 && k == n / 2) begin
          in_if.valid <= 1'b0;
          do @(posedge clk); while (windows_due.size() != 0);
        end
        send_item(rand_sample(), 1'b0, '0);
      end
      phase++;
    end

    // Many one-sample planes: each item is a window, so the channel field
    // climbs through every plane and the tensor wraps.
    settle();
    idle_mode = IDLE_NONE;
    vals = '{1, 1, DEEP_CHANNELS, 1, 1, 1, 1};
    for (r_i = 0; r_i < 7; r_i++) write_reg(CFG_IDX_BITS'(r_i), CFG_DATA_BITS'(vals[r_i]));
    for (k = 0; k < DEEP_CHANNELS + 6; k++) send_item(rand_sample(), 1'b0, '0);

    // The widest plane with the widest kernel and the largest column stride.
    settle();
    idle_mode = IDLE_BOTH;
    vals = '{POOL_MAX_WIDTH, 2, 1, 1, POOL_MAX_KERNEL, 2, STRIDE_LIMIT};
    for (r_i = 0; r_i < 7; r_i++) write_reg(CFG_IDX_BITS'(r_i), CFG_DATA_BITS'(vals[r_i]));
    for (k = 0; k < POOL_MAX_WIDTH + 4; k++) send_item(rand_sample(), 1'b0, '0);

    settle();
    $display("Sent %0d items (%0d from the table) over %0d random settings; %0d windows checked.",
             items_sent, dir_items, phase + 2, results_checked);
    $display("Settings spanned zero and saturated registers, oversized kernels, tensor wraps "
             , "and long output stalls.");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run.
  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mp2d_pkg.sv
rtl/mp2d_if.sv
rtl/mp2d_ctrl.sv
rtl/mp2d_datapath.sv
rtl/max_pool_2d_stream.sv
rtl/mp2d_checker.sv
tb/sv/tb_max_pool_2d_stream.sv
